// ----- rtl/ppr_pkg.sv -----
// ppr_pkg: shared constants and types for the payload pattern replacer
// no dependencies; imported by payload_pattern_replacer
package ppr_pkg;

  localparam int unsigned PatternMax = 8;
  localparam int unsigned LenW       = 4;
  localparam int unsigned WinDepth   = PatternMax - 1;
  localparam int unsigned WinCntW    = 3;
  localparam int unsigned FifoDepth  = 16;
  localparam int unsigned FifoPtrW   = 4;
  localparam int unsigned FifoCntW   = 5;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;

  // default pattern "carne" and replacement "PESCE", first byte in bits 7:0
  localparam logic [63:0]     PatternReset = 64'd435644686691;
  localparam logic [63:0]     ReplaceReset = 64'd297482274128;
  localparam logic [LenW-1:0] LengthReset  = 4'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN = 2'd0,
    CFG_REPLACE = 2'd1,
    CFG_LENGTH  = 2'd2
  } ppr_cfg_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       modified;
  } ppr_entry_t;

endpackage

// ----- rtl/payload_pattern_replacer.sv -----
// payload_pattern_replacer: streaming fixed-string search and replace, top level
// depends on ppr_pkg (constants, config register codes, result entry type)

// Takes one payload byte per cycle and sustains one byte per cycle in and out
// while neither side stalls. Each accepted byte joins a window of up to seven
// held bytes; one pass of logic scans the window greedily from the left,
// replaces every match of the pattern with the replacement string and pushes
// all finished bytes (up to eight, e.g. on the last byte of a packet when the
// window is flushed) into a sixteen-entry result queue in the same cycle.
// Input stall rises while the queue holds more than eight results, which only
// happens when the output side stalls. Bytes wait in the window until no match
// can start at them, so a byte leaves at most pattern_length-1 items later,
// or at end of packet. Configuration writes apply from the next accepted item.
module payload_pattern_replacer
  import ppr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic                packet_modified_o
);

  logic [63:0]     pattern_q, replace_q;
  logic [LenW-1:0] length_q;

  logic [7:0]         win_q [WinDepth];
  logic [WinCntW-1:0] win_cnt_q;
  logic               modified_q;

  ppr_entry_t          fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] fifo_cnt_q, fifo_cnt_d;

  logic [LenW-1:0] len;
  logic [LenW-1:0] cnt;
  logic [7:0]      buf_b  [PatternMax];
  logic [7:0]      emit_b [PatternMax];
  logic            match  [PatternMax];
  logic [LenW-1:0] n_emit;
  logic            any_match;
  logic            modified_d;
  logic            accept, pop;
  logic [LenW-1:0] n_push;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PatternReset;
      replace_q <= ReplaceReset;
      length_q  <= LengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN: pattern_q <= cfg_data_i;
        CFG_REPLACE: replace_q <= cfg_data_i;
        CFG_LENGTH:  length_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // length zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (length_q == '0) len = LenW'(1);
    else if (length_q > LenW'(PatternMax)) len = LenW'(PatternMax);
    else len = length_q;
  end

  assign cnt = LenW'(win_cnt_q) + LenW'(1);

  // held bytes followed by the new byte
  always_comb begin
    for (int j = 0; j < PatternMax; j++) begin
      buf_b[j] = data_byte_i;
      if (j < WinDepth && WinCntW'(j) < win_cnt_q) buf_b[j] = win_q[j];
    end
  end

  // a match can start at every position independently
  always_comb begin
    for (int p = 0; p < PatternMax; p++) begin
      match[p] = (LenW'(p) + len <= cnt);
      for (int i = 0; i < PatternMax; i++) begin
        if (LenW'(i) < len && p + i < PatternMax) begin
          if (buf_b[p+i] != pattern_q[8*i +: 8]) match[p] = 1'b0;
        end
      end
    end
  end

  // greedy left-to-right walk; finished bytes form a prefix of the window
  always_comb begin
    logic [LenW-1:0] rem;
    logic [2:0]      ridx;
    rem       = '0;
    ridx      = '0;
    n_emit    = '0;
    any_match = 1'b0;
    for (int p = 0; p < PatternMax; p++) begin
      emit_b[p] = buf_b[p];
      if (LenW'(p) < cnt) begin
        if (rem != '0) begin
          emit_b[p] = replace_q[8*ridx +: 8];
          rem       = rem - LenW'(1);
          ridx      = ridx + 3'd1;
          n_emit    = LenW'(p + 1);
        end else if (match[p]) begin
          emit_b[p] = replace_q[7:0];
          rem       = len - LenW'(1);
          ridx      = 3'd1;
          n_emit    = LenW'(p + 1);
          any_match = 1'b1;
        end else if ((cnt - LenW'(p) >= len) || last_byte_i) begin
          n_emit = LenW'(p + 1);
        end
      end
    end
  end

  assign modified_d = modified_q | any_match;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign n_push     = accept ? n_emit : '0;

  // window and per-packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cnt_q  <= '0;
      modified_q <= 1'b0;
    end else if (accept) begin
      if (last_byte_i) begin
        win_cnt_q  <= '0;
        modified_q <= 1'b0;
      end else begin
        win_cnt_q  <= WinCntW'(cnt - n_emit);
        modified_q <= modified_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int j = 0; j < WinDepth; j++) begin
        if (LenW'(j) + n_emit < LenW'(PatternMax)) begin
          win_q[j] <= buf_b[3'(LenW'(j) + n_emit)];
        end
      end
    end
  end

  // result queue: up to eight pushes and one pop per cycle
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < PatternMax; j++) begin
      if (LenW'(j) < n_push) begin
        fifo_q[wr_ptr_q + FifoPtrW'(j)].data     <= emit_b[j];
        fifo_q[wr_ptr_q + FifoPtrW'(j)].last     <=
          last_byte_i && (LenW'(j) == n_emit - LenW'(1));
        fifo_q[wr_ptr_q + FifoPtrW'(j)].modified <=
          last_byte_i && (LenW'(j) == n_emit - LenW'(1)) && modified_d;
      end
    end
  end

  assign fifo_cnt_d = fifo_cnt_q + FifoCntW'(n_push) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + FifoPtrW'(n_push);
      rd_ptr_q   <= rd_ptr_q + FifoPtrW'(pop);
      fifo_cnt_q <= fifo_cnt_d;
    end
  end

  // room for a full flush must be left before taking an item
  assign in_stall_o        = fifo_cnt_q > FifoCntW'(FifoDepth - PatternMax);
  assign out_valid_o       = fifo_cnt_q != '0;
  assign out_byte_o        = fifo_q[rd_ptr_q].data;
  assign out_last_o        = fifo_q[rd_ptr_q].last;
  assign packet_modified_o = fifo_q[rd_ptr_q].modified;

endmodule
